### hdl/lbs_pkg.sv
// Shared types and constants for the linear blend skinning block.
// Used by every module under hdl; depends on nothing.
package lbs_pkg;

	localparam int NUM_BONES = 64;
	localparam int NUM_INF   = 4;
	localparam int NUM_ELEM  = 12;
	localparam int BONE_W    = 6;
	localparam int ELEM_W    = 4;
	localparam int WEIGHT_W  = 16;
	localparam int PROD_W    = 64;
	localparam int TV_W      = 50;
	localparam int WP_W      = TV_W + WEIGHT_W + 1;
	localparam int ACC_W     = WP_W - 15 + 2;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_VERTEX = 1'b1;

	typedef logic signed [31:0] word_t;
	typedef logic signed [TV_W-1:0] tval_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [BONE_W-1:0] bone_t;

	typedef word_t mat_arr_t [NUM_INF][NUM_ELEM];
	typedef tval_t tval_arr_t [NUM_INF][3];
	typedef weight_t weight_arr_t [NUM_INF];
	typedef bone_t bone_arr_t [NUM_INF];

endpackage

### hdl/linear_blend_vertex_skinning_top.sv
// Linear blend skinning of one vertex with four bone influences.
// An accepted vertex request moves through stages s1 to s6 to its result.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken. Palette writes give no result.
// Reset clears only the valid bits; the palette is undefined until written.
module linear_blend_vertex_skinning_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// write_bone, write_element, write_value, pos_x, pos_y, pos_z,
	// weights_packed, bones_packed, then zero fill
	input  logic [231:0] s_tdata,
	// req_type
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// saturated
	output logic         m_tuser
);

	logic en;
	logic accept;
	logic vertex;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	lbs_pkg::word_t px_s1, py_s1, pz_s1;
	lbs_pkg::weight_arr_t w_in, w_s1, w_s2, w_s3;
	lbs_pkg::bone_arr_t bone_in;
	lbs_pkg::mat_arr_t mat_s1;
	lbs_pkg::tval_arr_t tval_s3;
	lbs_pkg::word_t out_s6 [3];
	logic sat_s6;

	assign en       = !vld_s6 || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;
	assign vertex   = s_tuser == lbs_pkg::REQ_VERTEX;

	always_comb begin
		for (int i = 0; i < lbs_pkg::NUM_INF; i++) begin
			bone_in[i] = s_tdata[202 + lbs_pkg::BONE_W*i +: lbs_pkg::BONE_W];
			w_in[i]    = s_tdata[138 + lbs_pkg::WEIGHT_W*i +: lbs_pkg::WEIGHT_W];
		end
	end

	lbs_palette u_palette (
		.clk      (clk),
		.en       (accept),
		.wr       (s_tuser == lbs_pkg::REQ_WRITE),
		.wr_bone  (s_tdata[5:0]),
		.wr_elem  (s_tdata[9:6]),
		.wr_value (s_tdata[41:10]),
		.rd_bone  (bone_in),
		.rd_data  (mat_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid && vertex;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= s_tdata[73:42];
			py_s1 <= s_tdata[105:74];
			pz_s1 <= s_tdata[137:106];
			w_s1  <= w_in;
			w_s2  <= w_s1;
			w_s3  <= w_s2;
		end
	end

	lbs_xform u_xform (
		.clk     (clk),
		.en      (en),
		.px      (px_s1),
		.py      (py_s1),
		.pz      (pz_s1),
		.mat     (mat_s1),
		.tval_s3 (tval_s3)
	);

	lbs_blend u_blend (
		.clk    (clk),
		.en     (en),
		.tval   (tval_s3),
		.weight (w_s3),
		.out_s6 (out_s6),
		.sat_s6 (sat_s6)
	);

	assign m_tvalid = vld_s6;
	assign m_tdata  = {out_s6[2], out_s6[1], out_s6[0]};
	assign m_tuser  = sat_s6;

endmodule

### hdl/lbs_palette.sv
// Bone palette: one bank per influence and matrix element, so that all
// elements of four bones are read together. Depends on lbs_pkg.
module lbs_palette (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  wr,
	input  lbs_pkg::bone_t        wr_bone,
	input  logic [lbs_pkg::ELEM_W-1:0] wr_elem,
	input  lbs_pkg::word_t        wr_value,
	input  lbs_pkg::bone_arr_t    rd_bone,
	output lbs_pkg::mat_arr_t     rd_data
);

	// Each write goes to the element's bank of every influence replica.
	for (genvar i = 0; i < lbs_pkg::NUM_INF; i++) begin : g_inf
		for (genvar e = 0; e < lbs_pkg::NUM_ELEM; e++) begin : g_elem
			lbs_pkg::word_t bank [lbs_pkg::NUM_BONES];

			always_ff @(posedge clk) begin
				if (en && wr && wr_elem == lbs_pkg::ELEM_W'(e)) begin
					bank[wr_bone] <= wr_value;
				end
				if (en) begin
					rd_data[i][e] <= bank[rd_bone[i]];
				end
			end
		end
	end

endmodule

### hdl/lbs_xform.sv
// Affine transform of the position by each influence's bone matrix:
// a product stage and a sum stage. Depends on lbs_pkg.
module lbs_xform (
	input  logic                clk,
	input  logic                en,
	input  lbs_pkg::word_t      px,
	input  lbs_pkg::word_t      py,
	input  lbs_pkg::word_t      pz,
	input  lbs_pkg::mat_arr_t   mat,
	output lbs_pkg::tval_arr_t  tval_s3
);

	logic signed [lbs_pkg::PROD_W-1:0] prod_s2 [lbs_pkg::NUM_INF][9];
	lbs_pkg::word_t trans_s2 [lbs_pkg::NUM_INF][3];

	for (genvar i = 0; i < lbs_pkg::NUM_INF; i++) begin : g_inf
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s2[i][c]     <= px * mat[i][c];
					prod_s2[i][3 + c] <= py * mat[i][3 + c];
					prod_s2[i][6 + c] <= pz * mat[i][6 + c];
					trans_s2[i][c]    <= mat[i][9 + c];
				end
			end

			// Arithmetic shift rounds toward minus infinity, as required.
			always_ff @(posedge clk) begin
				if (en) begin
					tval_s3[i][c] <= lbs_pkg::TV_W'(prod_s2[i][c] >>> 16)
						+ lbs_pkg::TV_W'(prod_s2[i][3 + c] >>> 16)
						+ lbs_pkg::TV_W'(prod_s2[i][6 + c] >>> 16)
						+ lbs_pkg::TV_W'(trans_s2[i][c]);
				end
			end
		end
	end

endmodule

### hdl/lbs_blend.sv
// Weighting, summation over influences and clamping to 32 bits.
// Three register stages; depends on lbs_pkg.
module lbs_blend (
	input  logic                  clk,
	input  logic                  en,
	input  lbs_pkg::tval_arr_t    tval,
	input  lbs_pkg::weight_arr_t  weight,
	output lbs_pkg::word_t        out_s6 [3],
	output logic                  sat_s6
);

	logic signed [lbs_pkg::WP_W-1:0] wp_s4 [lbs_pkg::NUM_INF][3];
	logic signed [lbs_pkg::ACC_W-1:0] acc_s5 [3];
	logic signed [lbs_pkg::ACC_W-1:0] acc_sum [3];
	logic [2:0] over;

	for (genvar i = 0; i < lbs_pkg::NUM_INF; i++) begin : g_inf
		for (genvar c = 0; c < 3; c++) begin : g_col
			always_ff @(posedge clk) begin
				if (en) begin
					wp_s4[i][c] <= tval[i][c] * $signed({1'b0, weight[i]});
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_sum[c] = '0;
			for (int i = 0; i < lbs_pkg::NUM_INF; i++) begin
				acc_sum[c] = acc_sum[c] + lbs_pkg::ACC_W'(wp_s4[i][c] >>> 15);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s5 <= acc_sum;
		end
	end

	// A value is out of range when it differs from the sign extension of its low word.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			over[c] = acc_s5[c] != lbs_pkg::ACC_W'($signed(acc_s5[c][31:0]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (!over[c]) begin
					out_s6[c] <= acc_s5[c][31:0];
				end else if (acc_s5[c][lbs_pkg::ACC_W-1]) begin
					out_s6[c] <= 32'sh8000_0000;
				end else begin
					out_s6[c] <= 32'sh7FFF_FFFF;
				end
			end
			sat_s6 <= |over;
		end
	end

endmodule

### dv/testbench.sv
// Self-checking bench for the linear blend skinning top: palette writes and
// vertex requests go in, blended positions are predicted and compared.
// Depends on lbs_pkg and linear_blend_vertex_skinning_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	// Only these bones are fully loaded; every vertex request points at them.
	localparam int LOADED_BONES = 16;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic sat;
	} blend_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [231:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic         m_tuser;

	logic signed [31:0] palette [lbs_pkg::NUM_BONES*lbs_pkg::NUM_ELEM];
	blend_t             blend_queue [$];
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 errors = 0;
	int                 vertices_sent = 0;
	int                 writes_sent = 0;
	int                 results_seen = 0;
	int                 saturated_seen = 0;
	int                 idle_cycles = 0;

	linear_blend_vertex_skinning_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [63:0] bone_xform(int base, int c,
			logic signed [63:0] px, logic signed [63:0] py, logic signed [63:0] pz);
		logic signed [63:0] t;
		t = floor_shift(px * 64'(palette[base + c]), 16);
		t += floor_shift(py * 64'(palette[base + 3 + c]), 16);
		t += floor_shift(pz * 64'(palette[base + 6 + c]), 16);
		t += 64'(palette[base + 9 + c]);
		return t;
	endfunction

	function automatic logic signed [31:0] clamp_word(logic signed [63:0] v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic blend_t skin_vertex(logic [231:0] d);
		logic signed [63:0] p [3];
		logic signed [63:0] acc [3];
		logic signed [63:0] t, hi;
		logic [63:0] wts;
		logic [23:0] bones;
		logic [15:0] w;
		int b;
		blend_t r;
		logic sat;
		p[0] = 64'(signed'(d[73:42]));
		p[1] = 64'(signed'(d[105:74]));
		p[2] = 64'(signed'(d[137:106]));
		wts = d[201:138];
		bones = d[225:202];
		acc = '{0, 0, 0};
		for (int i = 0; i < lbs_pkg::NUM_INF; i++) begin
			w = wts[16*i +: 16];
			b = int'(bones[6*i +: 6]);
			if (w != 0 && b < lbs_pkg::NUM_BONES) begin
				for (int c = 0; c < 3; c++) begin
					t = bone_xform(b*lbs_pkg::NUM_ELEM, c, p[0], p[1], p[2]);
					hi = w[15] ? t : 64'sd0;
					acc[c] += hi + floor_shift(t * 64'(signed'({1'b0, w[14:0]})), 15);
				end
			end
		end
		sat = 1'b0;
		r.x = clamp_word(acc[0], sat);
		r.y = clamp_word(acc[1], sat);
		r.z = clamp_word(acc[2], sat);
		r.sat = sat;
		return r;
	endfunction

	// One request; the prediction is made when the handshake completes.
	// Valid stays high after the handshake so that requests can follow
	// back to back; it drops only while idling or when the bench drains.
	task automatic send_request(logic kind, logic [231:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (kind == lbs_pkg::REQ_VERTEX) begin
			blend_queue.push_back(skin_vertex(d));
			vertices_sent++;
		end else begin
			if (d[5:0] < lbs_pkg::NUM_BONES && d[9:6] < lbs_pkg::NUM_ELEM)
				palette[d[5:0]*lbs_pkg::NUM_ELEM + d[9:6]] = d[41:10];
			writes_sent++;
		end
		@(negedge clk);
	endtask

	task automatic write_element(int bone, int elem, logic [31:0] val);
		send_request(lbs_pkg::REQ_WRITE, {190'd0, val, 4'(elem), 6'(bone)});
	endtask

	task automatic send_vertex(logic [31:0] x, y, z, logic [63:0] wts, logic [23:0] bones);
		send_request(lbs_pkg::REQ_VERTEX, {6'd0, bones, wts, z, y, x, 42'd0});
	endtask

	// Pick one of the loaded bones, so that every index of a vertex request,
	// even one with zero weight, refers to a fully written matrix.
	function automatic logic [5:0] pick_bone(int nb);
		return 6'($urandom_range(nb - 1));
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (blend_queue.size() != 0) @(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		blend_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("%0t watchdog: no progress", $time);
				$display("== FAIL ==");
				$finish;
			end
		end
		if (m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser};
			results_seen++;
			if (m_tuser) saturated_seen++;
			if (blend_queue.size() == 0) begin
				errors++;
				$display("%0t unexpected result %h", $time, got);
			end else begin
				want = blend_queue.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.z !== want.z
						|| got.sat !== want.sat) begin
					errors++;
					$display("%0t mismatch: expected x=%h y=%h z=%h sat=%b, actual x=%h y=%h z=%h sat=%b",
						$time, want.x, want.y, want.z, want.sat,
						got.x, got.y, got.z, got.sat);
				end
			end
		end
	end

	// Bone 0 gets identity, bones 1 and 2 full scale and extreme, bones 3 to 15 mixed matrices.
	task automatic test_palette_load();
		for (int b = 0; b < LOADED_BONES; b++)
			for (int e = 0; e < lbs_pkg::NUM_ELEM; e++)
				write_element(b, e, (b == 0) ? ((e == 0 || e == 4 || e == 8) ? 32'h10000 : 0)
					: (b == 1) ? 32'h7fffffff : (b == 2) ? 32'h80000000 : $urandom());
		// Out-of-range element writes are ignored.
		write_element(5, 12, 32'hdeadbeef);
		write_element(6, 15, 32'h12345678);
	endtask

	task automatic test_directed_vertices();
		send_vertex(32'h10000, 32'h20000, 32'hfffd0000, 64'h0000_0000_0000_8000, 24'd0);
		send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 64'hffff, 24'd1);
		send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 64'hffff, 24'd1);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 64'hffff_ffff_ffff_ffff,
			{6'd2, 6'd1, 6'd2, 6'd1});
		send_vertex($urandom(), $urandom(), $urandom(), 64'd0,
			{6'd15, 6'd14, 6'd13, 6'd12});
		send_vertex(32'h12345, 32'hfff00000, 32'h1, 64'h2000_2000_2000_2000,
			{6'd15, 6'd10, 6'd3, 6'd0});
		send_vertex(32'h1, 32'hffffffff, 32'h0, 64'h0001_0001_0001_0001,
			{6'd11, 6'd12, 6'd5, 6'd9});
		send_vertex(32'h30000, 32'h30000, 32'h30000, 64'h0000_8000_0000_0000,
			{6'd4, 6'd0, 6'd0, 6'd0});
		wait_drained();
	endtask

	task automatic test_random_stream(int count, int idle_pct, int stall_pct);
		logic [63:0] wts;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				write_element($urandom_range(lbs_pkg::NUM_BONES - 1), $urandom_range(15),
					$urandom());
			else begin
				wts = {$urandom(), $urandom()};
				for (int i = 0; i < lbs_pkg::NUM_INF; i++)
					if ($urandom_range(3) == 0) wts[16*i +: 16] = 16'd0;
				if ($urandom_range(1))
					send_vertex($urandom(), $urandom(), $urandom(), wts,
						{pick_bone(LOADED_BONES), pick_bone(LOADED_BONES),
						pick_bone(LOADED_BONES), pick_bone(LOADED_BONES)});
				else
					send_vertex(32'($signed($urandom_range(2000000)) - 1000000),
						32'($signed($urandom_range(2000000)) - 1000000),
						32'($signed($urandom_range(2000000)) - 1000000),
						wts & 64'h3fff_3fff_3fff_3fff,
						{pick_bone(LOADED_BONES), pick_bone(LOADED_BONES),
						pick_bone(LOADED_BONES), pick_bone(LOADED_BONES)});
			end
		end
		wait_drained();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_palette_load();
		test_directed_vertices();
		test_random_stream(100, 0, 0);
		test_random_stream(100, 71, 0);
		test_random_stream(100, 0, 71);
		test_random_stream(100, 34, 34);
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d palette writes and %0d vertices; %0d results checked, %0d saturated.",
			writes_sent, vertices_sent, results_seen, saturated_seen);
		if (errors == 0 && blend_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
hdl/lbs_pkg.sv
hdl/lbs_palette.sv
hdl/lbs_xform.sv
hdl/lbs_blend.sv
hdl/linear_blend_vertex_skinning_top.sv
dv/testbench.sv
